[rtl/xtae_pkg.sv]
`timescale 1ns / 1ps

package xtae_pkg;

  localparam int unsigned MAX_NAME_BYTES = 8;

  localparam int unsigned NAME_W     = 64;
  localparam int unsigned LENGTH_W   = 4;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_LT    = 8'h3C;
  localparam logic [7:0] CHAR_GT    = 8'h3E;
  localparam logic [7:0] CHAR_EQ    = 8'h3D;
  localparam logic [7:0] CHAR_QUOTE = 8'h22;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;

  typedef enum logic {
    CFG_WANTED_NAME   = 1'b0,
    CFG_WANTED_LENGTH = 1'b1
  } cfg_index_e;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_END  = 2'd1,
    KIND_NONE = 2'd2
  } kind_e;

  typedef enum logic [6:0] {
    PH_IDLE    = 7'b0000001,
    PH_TAGNAME = 7'b0000010,
    PH_SEP     = 7'b0000100,
    PH_NAME    = 7'b0001000,
    PH_EQ      = 7'b0010000,
    PH_UNQ     = 7'b0100000,
    PH_QUOTED  = 7'b1000000
  } phase_e;

  typedef struct packed {
    logic       valid;
    kind_e      kind;
    logic [7:0] value;
  } result_t;

endpackage

[rtl/xtae_parser.sv]
`timescale 1ns / 1ps

module xtae_parser #(
  parameter int unsigned MaxNameBytes = xtae_pkg::MAX_NAME_BYTES
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [xtae_pkg::NAME_W-1:0]   wanted_name_i,
  input  logic [xtae_pkg::LENGTH_W-1:0] wanted_length_i,
  input  logic                          step_i,
  input  logic [7:0]                    tag_byte_i,
  input  logic                          tag_start_i,
  output xtae_pkg::result_t             result_o
);
  import xtae_pkg::*;

  localparam int unsigned PosW = $clog2(MaxNameBytes + 1);

  phase_e          phase_q, phase_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            diff_q, diff_d;
  logic            want_q, want_d;

  logic [PosW-1:0] eff_len;
  logic [PosW-1:0] name_pos;
  logic            name_diff;
  logic [7:0]      name_byte;
  logic            char_miss;
  logic            name_hit;
  logic            is_blank;
  logic            is_end;
  logic [7:0]      c;
  result_t         res;

  assign c        = tag_byte_i;
  assign is_blank = (c == CHAR_SPACE) || (c == CHAR_TAB);
  assign is_end   = (c == CHAR_GT) || (c == CHAR_NUL);

  assign eff_len = (wanted_length_i > LENGTH_W'(MaxNameBytes)) ?
                   PosW'(MaxNameBytes) : PosW'(wanted_length_i);

  // A name starts fresh on the first byte after a separator
  assign name_pos  = (phase_q == PH_SEP) ? '0 : pos_q;
  assign name_diff = (phase_q == PH_SEP) ? 1'b0 : diff_q;
  assign name_byte = 8'(wanted_name_i >> {name_pos, 3'b000});
  assign char_miss = (name_pos >= eff_len) || (name_byte != c);
  assign name_hit  = !diff_q && (pos_q == eff_len);

  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    diff_d    = diff_q;
    want_d    = want_q;
    res.valid = 1'b0;
    res.kind  = KIND_NONE;
    res.value = 8'h00;

    if (tag_start_i) begin
      pos_d  = '0;
      diff_d = 1'b0;
      want_d = 1'b0;
      if (c != CHAR_LT) begin
        res.valid = 1'b1;
        phase_d   = PH_IDLE;
      end else begin
        phase_d = PH_TAGNAME;
      end
    end else begin
      unique case (phase_q)
        PH_IDLE: begin
        end
        PH_TAGNAME: begin
          if (is_end) begin
            res.valid = 1'b1;
            phase_d   = PH_IDLE;
          end else if (is_blank) begin
            phase_d = PH_SEP;
          end
        end
        PH_SEP: begin
          if (is_end) begin
            res.valid = 1'b1;
            phase_d   = PH_IDLE;
          end else if (!is_blank) begin
            pos_d  = '0;
            diff_d = 1'b0;
            want_d = 1'b0;
            if (c == CHAR_EQ) begin
              // empty name matches only an empty wanted name
              want_d  = (eff_len == '0);
              phase_d = PH_EQ;
            end else begin
              if (char_miss) begin
                diff_d = 1'b1;
              end else begin
                pos_d = name_pos + PosW'(1);
              end
              phase_d = PH_NAME;
            end
          end
        end
        PH_NAME: begin
          if (c == CHAR_EQ || is_blank || is_end) begin
            want_d = name_hit;
            if (c == CHAR_EQ) begin
              phase_d = PH_EQ;
            end else if (name_hit) begin
              res.valid = 1'b1;
              res.kind  = KIND_END;
              phase_d   = PH_IDLE;
            end else if (is_blank) begin
              phase_d = PH_SEP;
            end else begin
              res.valid = 1'b1;
              phase_d   = PH_IDLE;
            end
          end else if (!name_diff) begin
            if (char_miss) begin
              diff_d = 1'b1;
            end else begin
              pos_d = name_pos + PosW'(1);
            end
          end
        end
        PH_EQ, PH_UNQ: begin
          if (phase_q == PH_EQ && c == CHAR_QUOTE) begin
            phase_d = PH_QUOTED;
          end else if (is_end || is_blank) begin
            if (want_q) begin
              res.valid = 1'b1;
              res.kind  = KIND_END;
              phase_d   = PH_IDLE;
            end else if (is_blank) begin
              phase_d = PH_SEP;
            end else begin
              res.valid = 1'b1;
              phase_d   = PH_IDLE;
            end
          end else begin
            phase_d = PH_UNQ;
            if (want_q) begin
              res.valid = 1'b1;
              res.kind  = KIND_BYTE;
              res.value = c;
            end
          end
        end
        PH_QUOTED: begin
          if (c == CHAR_QUOTE) begin
            if (want_q) begin
              res.valid = 1'b1;
              res.kind  = KIND_END;
              phase_d   = PH_IDLE;
            end else begin
              phase_d = PH_SEP;
            end
          end else if (c == CHAR_NUL) begin
            res.valid = 1'b1;
            res.kind  = want_q ? KIND_END : KIND_NONE;
            phase_d   = PH_IDLE;
          end else if (want_q) begin
            res.valid = 1'b1;
            res.kind  = KIND_BYTE;
            res.value = c;
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      pos_q   <= '0;
      diff_q  <= 1'b0;
      want_q  <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      diff_q  <= diff_d;
      want_q  <= want_d;
    end
  end

  assign result_o = res;

endmodule

[rtl/xml_tag_attribute_extractor.sv]
`timescale 1ns / 1ps

// Attribute value extractor for markup tags.
// Config: write wanted_name (index 0, first character in the low byte) and
// wanted_length (index 1) through cfg_we_i/cfg_index_i/cfg_data_i while idle.
// Input channel: one tag byte per item with tag_start_i marking the '<' that
// opens a tag; tag_start_i restarts the parse at any point.
// Output channel: at most one item per input byte: a value byte (kind 0), the
// end of the found value (kind 1) or not found (kind 2). Bytes that produce
// nothing are absorbed silently; after a marker the block ignores bytes until
// the next tag start.
// Timing: an accepted byte is held in the input register while it is parsed;
// its result loads into the output register when the byte advances. One byte
// per cycle is sustained while the receiver takes each item; the parse state
// update is a single compare against one name byte plus phase logic.
// Stall: when the output register holds an item that is not taken, the
// input register fills and in_ready_o drops until the receiver drains.
// Reset clears the parse state, the config registers and both valid flags.
module xml_tag_attribute_extractor #(
  parameter int unsigned MaxNameBytes = xtae_pkg::MAX_NAME_BYTES
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic                            cfg_index_i,
  input  logic [xtae_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [7:0]                      tag_byte_i,
  input  logic                            tag_start_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [1:0]                      result_kind_o,
  output logic [7:0]                      value_byte_o
);
  import xtae_pkg::*;

  logic [NAME_W-1:0]   wanted_name_q;
  logic [LENGTH_W-1:0] wanted_length_q;

  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_start_q;
  logic       accept;
  logic       advance;

  logic       out_valid_q;
  kind_e      out_kind_q;
  logic [7:0] out_byte_q;

  result_t    step_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wanted_name_q   <= '0;
      wanted_length_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_WANTED_NAME:   wanted_name_q   <= NAME_W'(cfg_data_i);
        CFG_WANTED_LENGTH: wanted_length_q <= cfg_data_i[LENGTH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // advance the held item whenever the output register can take its result
  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_byte_q  <= tag_byte_i;
      s1_start_q <= tag_start_i;
    end
  end

  xtae_parser #(
    .MaxNameBytes(MaxNameBytes)
  ) u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .wanted_name_i  (wanted_name_q),
    .wanted_length_i(wanted_length_q),
    .step_i         (advance),
    .tag_byte_i     (s1_byte_q),
    .tag_start_i    (s1_start_q),
    .result_o       (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= step_res.valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_kind_q <= step_res.kind;
      out_byte_q <= step_res.value;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = out_kind_q;
  assign value_byte_o  = out_byte_q;

endmodule

[rtl/xtae_checker.sv]
`timescale 1ns / 1ps

module xtae_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] result_kind_o,
  input logic [7:0] value_byte_o
);
  import xtae_pkg::*;

  // hold a stalled result item
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_kind_o)
      && $stable(value_byte_o))
    else $error("stalled result item changed");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (result_kind_o == KIND_BYTE) || (result_kind_o == KIND_END)
      || (result_kind_o == KIND_NONE))
    else $error("illegal result kind");

  a_marker_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o != KIND_BYTE) |-> value_byte_o == 8'h00)
    else $error("marker item carries a nonzero byte");

  // input backpressure only comes from a stalled output
  a_ready_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

endmodule

bind xml_tag_attribute_extractor xtae_checker u_xtae_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .result_kind_o(result_kind_o),
  .value_byte_o (value_byte_o)
);

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
  import xtae_pkg::*;

  localparam int unsigned ITEM_TARGET    = 1900;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned PIPE_SETTLE    = 4;

  typedef enum int unsigned {
    PACE_FULL,
    PACE_RANDOM,
    PACE_SPARSE
  } pace_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] value;
  } attr_result_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  cfg_index_e            cfg_index_i   = CFG_WANTED_NAME;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  in_valid_i    = 1'b0;
  logic                  in_ready_o;
  logic [7:0]            tag_byte_i    = '0;
  logic                  tag_start_i   = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i   = 1'b0;
  logic [1:0]            result_kind_o;
  logic [7:0]            value_byte_o;

  xml_tag_attribute_extractor u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .tag_byte_i    (tag_byte_i),
    .tag_start_i   (tag_start_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_kind_o (result_kind_o),
    .value_byte_o  (value_byte_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Parser copy, advanced once per accepted item
  phase_e      parse_phase = PH_IDLE;
  logic [3:0]  name_pos    = '0;
  logic        name_miss   = 1'b0;
  logic        attr_hit    = 1'b0;
  logic [63:0] want_name   = '0;
  logic [3:0]  want_len    = '0;

  attr_result_t attr_value_q[$];

  pace_e       tx_pace       = PACE_FULL;
  pace_e       rx_pace       = PACE_FULL;
  int unsigned hold_cycles   = 0;
  int unsigned bytes_counted = 0;
  int unsigned fault_count   = 0;
  int unsigned quiet_cycles  = 0;

  function automatic logic [3:0] clipped_len();
    return (want_len > MAX_NAME_BYTES) ? 4'(MAX_NAME_BYTES) : want_len;
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return c == CHAR_SPACE || c == CHAR_TAB;
  endfunction

  function automatic void post(kind_e k, logic [7:0] v);
    attr_value_q.push_back('{kind: k, value: v});
    if (k != KIND_BYTE) parse_phase = PH_IDLE;
  endfunction

  // A blank lets more attributes follow; '>' or zero ends the tag
  function automatic void close_item(logic [7:0] c);
    if (is_blank(c)) parse_phase = PH_SEP;
    else post(KIND_NONE, 8'h00);
  endfunction

  function automatic void close_name(logic [7:0] c);
    attr_hit = !name_miss && name_pos == clipped_len();
    if (c == CHAR_EQ) parse_phase = PH_EQ;
    else if (attr_hit) post(KIND_END, 8'h00);
    else close_item(c);
  endfunction

  function automatic void match_name_char(logic [7:0] c);
    if (!name_miss) begin
      if (name_pos >= clipped_len() || want_name[8*name_pos +: 8] != c) name_miss = 1'b1;
      else name_pos++;
    end
  endfunction

  function automatic void unquoted_char(logic [7:0] c);
    if (c == CHAR_NUL || c == CHAR_GT || is_blank(c)) begin
      if (attr_hit) post(KIND_END, 8'h00);
      else close_item(c);
    end else begin
      parse_phase = PH_UNQ;
      if (attr_hit) post(KIND_BYTE, c);
    end
  endfunction

  function automatic void extract_step(logic [7:0] c, logic st);
    if (st) begin
      name_pos  = '0;
      name_miss = 1'b0;
      attr_hit  = 1'b0;
      if (c != CHAR_LT) post(KIND_NONE, 8'h00);
      else parse_phase = PH_TAGNAME;
    end else begin
      case (parse_phase)
        PH_TAGNAME: begin
          if (c == CHAR_GT || c == CHAR_NUL) post(KIND_NONE, 8'h00);
          else if (is_blank(c)) parse_phase = PH_SEP;
        end
        PH_SEP: begin
          if (c == CHAR_GT || c == CHAR_NUL) begin
            post(KIND_NONE, 8'h00);
          end else if (!is_blank(c)) begin
            name_pos  = '0;
            name_miss = 1'b0;
            attr_hit  = 1'b0;
            // '=' right here is an empty attribute name
            if (c == CHAR_EQ) begin
              close_name(c);
            end else begin
              match_name_char(c);
              parse_phase = PH_NAME;
            end
          end
        end
        PH_NAME: begin
          if (c == CHAR_EQ || is_blank(c) || c == CHAR_GT || c == CHAR_NUL) close_name(c);
          else match_name_char(c);
        end
        PH_EQ: begin
          if (c == CHAR_QUOTE) parse_phase = PH_QUOTED;
          else unquoted_char(c);
        end
        PH_UNQ: unquoted_char(c);
        PH_QUOTED: begin
          if (c == CHAR_QUOTE) begin
            if (attr_hit) post(KIND_END, 8'h00);
            else parse_phase = PH_SEP;
          end else if (c == CHAR_NUL) begin
            post(attr_hit ? KIND_END : KIND_NONE, 8'h00);
          end else if (attr_hit) begin
            post(KIND_BYTE, c);
          end
        end
        default: parse_phase = PH_IDLE;
      endcase
    end
  endfunction

  function automatic int unsigned draw_wait(pace_e pace);
    case (pace)
      PACE_RANDOM: return $urandom_range(0, 14);
      PACE_SPARSE: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 14) : 0;
      default:     return 0;
    endcase
  endfunction

  function automatic void flag_fault(string msg);
    fault_count++;
    if (fault_count <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
  endfunction

  // Any byte that cannot end an attribute name
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == CHAR_NUL || is_blank(c) || c == CHAR_EQ || c == CHAR_GT);
    return c;
  endfunction

  function automatic logic [7:0] value_char(logic quoted);
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == CHAR_NUL || c == CHAR_QUOTE ||
           (!quoted && (is_blank(c) || c == CHAR_GT)));
    return c;
  endfunction

  function automatic logic [63:0] pack_name(string s);
    logic [63:0] w;
    w = '0;
    for (int i = 0; i < s.len() && i < 8; i++) w[8*i +: 8] = s[i];
    return w;
  endfunction

  // Called at a falling edge; returns at a falling edge with valid dropped
  task automatic send_byte(logic [7:0] c, logic st);
    int unsigned gap;
    gap = draw_wait(tx_pace);
    repeat (gap) @(negedge clk_i);
    in_valid_i  = 1'b1;
    tag_byte_i  = c;
    tag_start_i = st;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_counted++;
    extract_step(c, st);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic send_text(string s, logic first_start);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], first_start && i == 0);
  endtask

  task automatic drain();
    while (attr_value_q.size() != 0) @(negedge clk_i);
  endtask

  // Wait out results and any byte still in flight that yields nothing
  task automatic settle();
    drain();
    repeat (PIPE_SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_index_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CFG_WANTED_NAME) want_name = val;
    else want_len = val[3:0];
  endtask

  task automatic test_directed();
    settle();
    write_reg(CFG_WANTED_NAME, pack_name("a"));
    write_reg(CFG_WANTED_LENGTH, 64'd1);
    tx_pace = PACE_RANDOM;
    rx_pace = PACE_RANDOM;
    send_byte("q", 1'b0);             // idle, no tag start: dropped
    send_byte("x", 1'b1);             // tag opens without '<'
    send_text("<>", 1'b1);            // tag name cut by '>'
    send_text("<\ta>", 1'b1);         // wanted name with no value
    send_text("< c=\"", 1'b1);        // zero inside another quoted value
    send_byte(CHAR_NUL, 1'b0);
    // closing quote runs straight into the wanted name, zero ends its value
    send_text("<\tb=\"\"a=\"", 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(CHAR_NUL, 1'b0);
    send_byte("z", 1'b0);             // after the marker: dropped
  endtask

  task automatic test_name_edges();
    settle();
    write_reg(CFG_WANTED_LENGTH, 64'd0);
    send_text("< x =v>", 1'b1);       // only the empty name matches
    settle();
    write_reg(CFG_WANTED_NAME, '1);
    write_reg(CFG_WANTED_LENGTH, 64'd15);
    send_text("< ", 1'b1);
    repeat (8) send_byte(8'hFF, 1'b0);
    send_text("=q ", 1'b0);
    settle();
    // second name byte is zero, which the tag can never supply
    write_reg(CFG_WANTED_NAME, pack_name("a"));
    write_reg(CFG_WANTED_LENGTH, 64'd2);
    send_text("< a", 1'b1);
    send_byte(CHAR_NUL, 1'b0);
  endtask

  task automatic test_backpressure();
    settle();
    write_reg(CFG_WANTED_NAME, pack_name("key"));
    write_reg(CFG_WANTED_LENGTH, 64'd3);
    tx_pace     = PACE_FULL;
    hold_cycles = 300;
    send_text("< key=\"", 1'b1);
    repeat (48) send_byte(value_char(1'b1), 1'b0);
    send_byte(CHAR_QUOTE, 1'b0);
    drain();
    rx_pace = PACE_RANDOM;
    send_text("<t key=v1 x>", 1'b1);
  endtask

  task automatic test_random_tags();
    logic [63:0] name_word;
    logic [3:0]  elen;
    int unsigned nlen;
    int unsigned vlen;
    int unsigned form;
    int unsigned pick;
    while (bytes_counted < ITEM_TARGET) begin
      settle();
      if ($urandom_range(0, 3) != 0) begin
        for (int i = 0; i < 8; i++)
          name_word[8*i +: 8] = ($urandom_range(0, 7) == 0) ? 8'($urandom) : plain_char();
        write_reg(CFG_WANTED_NAME, name_word);
      end
      write_reg(CFG_WANTED_LENGTH, 64'($urandom_range(0, 15)));
      elen    = clipped_len();
      tx_pace = pace_e'($urandom_range(0, 2));
      rx_pace = pace_e'($urandom_range(0, 2));
      repeat ($urandom_range(10, 30)) begin
        if ($urandom_range(0, 7) == 0) begin
          // raw bytes, now and then flagged as a tag start
          repeat ($urandom_range(1, 12))
            send_byte(8'($urandom), $urandom_range(0, 5) == 0);
        end else begin
          send_byte(CHAR_LT, 1'b1);
          repeat ($urandom_range(0, 3)) send_byte(plain_char(), 1'b0);
          repeat ($urandom_range(0, 4)) begin
            repeat (($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 2))
              send_byte(($urandom_range(0, 1) == 0) ? CHAR_SPACE : CHAR_TAB, 1'b0);
            form = $urandom_range(0, 7);
            if (form < 4) begin
              // wanted name, sometimes one byte short or one byte long
              nlen = elen;
              if (form == 0 && nlen > 0) nlen--;
              else if (form == 1) nlen++;
              for (int i = 0; i < nlen; i++)
                send_byte((i < elen) ? want_name[8*i +: 8] : plain_char(), 1'b0);
            end else begin
              nlen = $urandom_range(0, 9);
              for (int i = 0; i < nlen; i++) begin
                pick = $urandom_range(0, 7);
                send_byte(($urandom_range(0, 1) == 0) ? want_name[8*pick +: 8] : plain_char(),
                          1'b0);
              end
            end
            form = $urandom_range(0, 3);
            vlen = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
            if (form == 1) begin
              send_byte(CHAR_EQ, 1'b0);
              repeat (vlen) send_byte(value_char(1'b0), 1'b0);
            end else if (form >= 2) begin
              send_byte(CHAR_EQ, 1'b0);
              send_byte(CHAR_QUOTE, 1'b0);
              repeat (vlen) send_byte(value_char(1'b1), 1'b0);
              send_byte(($urandom_range(0, 9) == 0) ? CHAR_NUL : CHAR_QUOTE, 1'b0);
            end
          end
          form = $urandom_range(0, 9);
          if (form < 6) send_byte(CHAR_GT, 1'b0);
          else if (form < 8) send_byte(CHAR_NUL, 1'b0);
          // otherwise leave the tag open for the next start to cut off
        end
      end
    end
  endtask

  // Receiver: random stalls per item, or one long hold when asked
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_cycles != 0) begin
        out_ready_i = 1'b0;
        repeat (hold_cycles) @(negedge clk_i);
        hold_cycles = 0;
      end else begin
        stall = draw_wait(rx_pace);
        if (stall != 0) begin
          out_ready_i = 1'b0;
          repeat (stall) @(negedge clk_i);
        end
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o && hold_cycles == 0);
    end
  end

  always @(posedge clk_i) begin
    attr_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (attr_value_q.size() == 0) begin
        flag_fault($sformatf("unexpected item: kind %0d byte %02h",
                             result_kind_o, value_byte_o));
      end else begin
        want = attr_value_q.pop_front();
        if (result_kind_o !== want.kind || value_byte_o !== want.value)
          flag_fault($sformatf("expected kind %0d byte %02h, got kind %0d byte %02h",
                               want.kind, want.value, result_kind_o, value_byte_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_name_edges();
    test_backpressure();
    test_random_tags();
    drain();
    repeat (8) @(negedge clk_i);
    if (fault_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/xtae_pkg.sv
rtl/xtae_parser.sv
rtl/xml_tag_attribute_extractor.sv
rtl/xtae_checker.sv
verif/tb.sv
